@@ design/msp_pkg.sv @@
// Shared types, codes and the path reduction table for the maze path shortener.
`default_nettype none

package msp_pkg;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_FETCH  = 2'd1,
        CMD_REWIND = 2'd2
    } t_cmd;

    // Move codes.
    localparam logic [1:0] MV_L = 2'd0;
    localparam logic [1:0] MV_S = 2'd1;
    localparam logic [1:0] MV_R = 2'd2;
    localparam logic [1:0] MV_B = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic issue;   // word taken: start memory access
        logic commit;  // update state and load the result register
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // result register can be loaded this cycle
    } t_ctl_sts;

    typedef struct packed {
        logic       hit;
        logic [1:0] mv;
    } t_rule;

    // Replacement for the triple prev, B, curr.
    function automatic t_rule reduce_rule(input logic [1:0] prev, input logic [1:0] curr);
        t_rule r;
        r.hit = 1'b1;
        r.mv  = MV_L;
        case ({prev, curr})
            {MV_L, MV_L}: r.mv = MV_S;
            {MV_L, MV_S}: r.mv = MV_R;
            {MV_L, MV_R}: r.mv = MV_B;
            {MV_S, MV_L}: r.mv = MV_R;
            {MV_S, MV_S}: r.mv = MV_B;
            {MV_R, MV_L}: r.mv = MV_B;
            default:      r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/msp_ctrl.sv @@
// Controller state machine for the maze path shortener.
`default_nettype none

module msp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire msp_pkg::t_ctl_sts i_sts,
    output msp_pkg::t_ctl_cmd      o_cmd
);
    import msp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.issue  = 1'b0;
        o_cmd.commit = 1'b0;
        o_stall      = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall     = 1'b0;
                o_cmd.issue = i_valid;
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Hold here until the result register is free.
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ design/msp_dp.sv @@
// Datapath of the maze path shortener: move memory, counts, read position, result register.
`default_nettype none

module msp_dp #(
    parameter int PATH_DEPTH = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire msp_pkg::t_ctl_cmd i_cmd,
    output msp_pkg::t_ctl_sts      o_sts,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_data,
    input  wire logic [1:0]        i_command,
    input  wire logic [1:0]        i_move_code,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [1:0]             o_move_out,
    output logic                   o_has_move,
    output logic [7:0]             o_path_length,
    output logic                   o_dropped
);
    import msp_pkg::*;

    localparam int AW = $clog2(PATH_DEPTH);
    localparam int CW = $clog2(PATH_DEPTH + 1);
    localparam int MW = AW + 1;
    localparam int MD = 2 ** MW;

    // Both stacks share one memory; the bank is the top address bit.
    logic [1:0]    r_mem [MD];
    logic [1:0]    r_rd_a;
    logic [1:0]    r_rd_b;

    logic          r_bank;
    logic [CW-1:0] r_cnt0;
    logic [CW-1:0] r_cnt1;
    logic [CW-1:0] r_rp;

    t_cmd          r_cmd;
    logic [1:0]    r_move;
    logic          r_full;
    logic          r_fetch_ok;

    logic          r_o_valid;
    logic [1:0]    r_move_out;
    logic          r_has_move;
    logic [7:0]    r_path_len;
    logic          r_dropped;

    logic [CW-1:0] cur_cnt;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic          cur_full;
    logic [MW-1:0] rd_a_addr;
    logic [MW-1:0] rd_b_addr;
    logic          wr_en;
    logic [MW-1:0] wr_addr;
    logic [1:0]    wr_data;
    t_rule         rule;
    logic          red_hit;
    logic [CW-1:0] n_cur_cnt;
    logic [CW-1:0] n_rp;
    logic [CW+7:0] len_ext;
    logic          is_record;

    assign cur_cnt  = r_bank ? r_cnt1 : r_cnt0;
    assign cnt_m1   = cur_cnt - CW'(1);
    assign cnt_m2   = cur_cnt - CW'(2);
    assign cur_full = (cur_cnt >= CW'(PATH_DEPTH));
    assign is_record = (t_cmd'(i_command) == CMD_RECORD);

    assign rd_a_addr = is_record ? {r_bank, cnt_m1[AW-1:0]} : {r_bank, r_rp[AW-1:0]};
    assign rd_b_addr = {r_bank, cnt_m2[AW-1:0]};

    // Triple is prev (below B), B, curr (the move just pushed).
    assign rule    = reduce_rule(r_rd_b, r_move);
    assign red_hit = (r_cmd == CMD_RECORD) && !r_full && (cur_cnt >= CW'(2))
                     && (r_rd_a == MV_B) && rule.hit;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {r_bank, cur_cnt[AW-1:0]};
        wr_data = i_move_code;
        if (i_cmd.issue && is_record && !cur_full) begin
            wr_en = 1'b1;
        end else if (i_cmd.commit && red_hit) begin
            wr_en   = 1'b1;
            wr_addr = {r_bank, cnt_m2[AW-1:0]};
            wr_data = rule.mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.issue) begin
            r_rd_a <= r_mem[rd_a_addr];
            r_rd_b <= r_mem[rd_b_addr];
        end
    end

    always_comb begin
        n_cur_cnt = cur_cnt;
        n_rp      = r_rp;
        case (r_cmd)
            CMD_RECORD: begin
                if (!r_full) begin
                    n_cur_cnt = red_hit ? cnt_m1 : cur_cnt + CW'(1);
                end
            end
            CMD_FETCH: begin
                if (r_fetch_ok) begin
                    n_rp = r_rp + CW'(1);
                end
            end
            CMD_REWIND: begin
                n_rp = '0;
            end
            default: begin
            end
        endcase
    end

    assign len_ext = {8'd0, n_cur_cnt};

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_cmd      <= t_cmd'(i_command);
            r_move     <= i_move_code;
            r_full     <= cur_full;
            r_fetch_ok <= (r_rp < cur_cnt);
        end
        if (i_cmd.commit) begin
            r_move_out <= (r_cmd == CMD_FETCH && r_fetch_ok) ? r_rd_a : MV_L;
            r_has_move <= (r_cmd == CMD_FETCH) && r_fetch_ok;
            r_path_len <= len_ext[7:0];
            r_dropped  <= (r_cmd == CMD_RECORD) && r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank    <= 1'b0;
            r_cnt0    <= '0;
            r_cnt1    <= '0;
            r_rp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bank <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_rp <= n_rp;
                if (r_bank) begin
                    r_cnt1 <= n_cur_cnt;
                end else begin
                    r_cnt0 <= n_cur_cnt;
                end
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_o_valid || !i_stall;
    assign o_valid        = r_o_valid;
    assign o_move_out     = r_move_out;
    assign o_has_move     = r_has_move;
    assign o_path_length  = r_path_len;
    assign o_dropped      = r_dropped;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt0 <= CW'(PATH_DEPTH)) && (r_cnt1 <= CW'(PATH_DEPTH)))
        else $error("stack count beyond depth");
    a_rp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= CW'(PATH_DEPTH))
        else $error("read position beyond depth");
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_o_valid)
        else $error("result not presented after commit");
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_o_valid || !i_stall))
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ design/maze_path_shortener.sv @@
// Top level of the maze path shortener: two move stacks with LSRB path reduction.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------------
//  input    | i_valid / o_stall           | i_command, i_move_code
//  output   | o_valid / i_stall           | o_move_out, o_has_move, o_path_length, o_dropped
//  config   | i_cfg_we                    | i_cfg_data (active bank)
//
// On acceptance a word writes a recorded move and reads the memory; in the execute
// state that follows, it applies the reduction table and loads the result register.
// A stalled result holds the datapath in its execute state; a new word is still taken
// while a finished result waits. Reset is synchronous and active low; it clears
// the counts, the read position and the bank. Stored moves are not cleared.
`default_nettype none

module maze_path_shortener #(
    parameter int PATH_DEPTH = 128
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_command,
    input  wire logic [1:0] i_move_code,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_move_out,
    output logic            o_has_move,
    output logic [7:0]      o_path_length,
    output logic            o_dropped
);
    import msp_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;

    msp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (ctl_sts),
        .o_cmd   (ctl_cmd)
    );

    msp_dp #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctl_cmd),
        .o_sts         (ctl_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_move_code   (i_move_code),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_move_out    (o_move_out),
        .o_has_move    (o_has_move),
        .o_path_length (o_path_length),
        .o_dropped     (o_dropped)
    );

endmodule

`default_nettype wire

@@ verif/maze_path_shortener_test.sv @@
// Self-checking testbench for the maze path shortener: random and directed words with a predictor.
`timescale 1ns / 100ps

module maze_path_shortener_test;
    import msp_pkg::*;

    localparam int PATH_DEPTH = 128;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    // The command field has one code the block does not use.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] mv;
    } t_move_word;

    typedef struct packed {
        logic [1:0] move_out;
        logic       has_move;
        logic [7:0] path_len;
        logic       dropped;
    } t_path_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       i_valid = 1'b0;
    logic [1:0] i_command = CMD_RECORD;
    logic [1:0] i_move_code = MV_L;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [1:0] o_move_out;
    logic       o_has_move;
    logic [7:0] o_path_length;
    logic       o_dropped;

    // Mirror of the two move stacks, the shared read position and the bank select.
    logic [1:0]  path_mem [2][PATH_DEPTH];
    int unsigned path_cnt [2] = '{0, 0};
    int unsigned rd_pos = 0;
    logic        bank_sel = 1'b0;

    t_move_word   word_queue [$];
    t_path_result path_results_due [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    logic gap_taken = 1'b0;
    logic in_fire = 1'b0;
    int  mismatches = 0;
    int  quiet_cycles = 0;

    maze_path_shortener #(
        .PATH_DEPTH(PATH_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_command(i_command),
        .i_move_code(i_move_code),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_move_out(o_move_out),
        .o_has_move(o_has_move),
        .o_path_length(o_path_length),
        .o_dropped(o_dropped)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Returns {hit, replacement} for the dead-end triple prev, B, curr.
    function automatic logic [2:0] collapse_rule(input logic [1:0] prev, input logic [1:0] curr);
        case ({prev, curr})
            {MV_L, MV_L}: return {1'b1, MV_S};
            {MV_L, MV_S}: return {1'b1, MV_R};
            {MV_L, MV_R}: return {1'b1, MV_B};
            {MV_S, MV_L}: return {1'b1, MV_R};
            {MV_S, MV_S}: return {1'b1, MV_B};
            {MV_R, MV_L}: return {1'b1, MV_B};
            default:      return {1'b0, MV_L};
        endcase
    endfunction

    task automatic apply_word(input logic [1:0] cmd, input logic [1:0] mv);
        t_path_result res;
        int unsigned  n;
        logic [2:0]   rule;
        res = '0;
        n = path_cnt[bank_sel];
        case (cmd)
            CMD_RECORD: begin
                if (n >= PATH_DEPTH) begin
                    res.dropped = 1'b1;
                end else begin
                    path_mem[bank_sel][n] = mv;
                    n++;
                    if (n >= 3 && path_mem[bank_sel][n - 2] == MV_B) begin
                        rule = collapse_rule(path_mem[bank_sel][n - 3], mv);
                        if (rule[2]) begin
                            path_mem[bank_sel][n - 3] = rule[1:0];
                            n -= 2;
                        end
                    end
                    path_cnt[bank_sel] = n;
                end
            end
            CMD_FETCH: begin
                if (rd_pos < n) begin
                    res.move_out = path_mem[bank_sel][rd_pos];
                    res.has_move = 1'b1;
                    rd_pos++;
                end
            end
            CMD_REWIND: begin
                rd_pos = 0;
            end
            default: begin
            end
        endcase
        res.path_len = n[7:0];
        path_results_due.push_back(res);
    endtask

    task automatic queue_word(input logic [1:0] cmd, input logic [1:0] mv);
        t_move_word w;
        w.cmd = cmd;
        w.mv = mv;
        word_queue.push_back(w);
    endtask

    // A dead end and its way back: a move, then B plus a move that mostly
    // collapses with the current top, repeated a few times.
    task automatic queue_detour();
        logic [1:0] top;
        logic [1:0] curr;
        logic [2:0] rule;
        int         steps;
        top = 2'($urandom_range(MV_L, MV_R));
        steps = $urandom_range(1, 4);
        queue_word(CMD_RECORD, top);
        for (int k = 0; k < steps && top != MV_B; k++) begin
            if ($urandom_range(0, 4) == 0)
                curr = 2'($urandom_range(MV_L, MV_B));
            else
                curr = 2'($urandom_range(0, 2 - top));
            queue_word(CMD_RECORD, MV_B);
            queue_word(CMD_RECORD, curr);
            rule = collapse_rule(top, curr);
            top = rule[2] ? rule[1:0] : curr;
        end
    endtask

    task automatic queue_random_words(input int count);
        int goal;
        int pick;
        goal = word_queue.size() + count;
        while (word_queue.size() < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                queue_detour();
            end else if (pick < 50) begin
                queue_word(CMD_RECORD, 2'($urandom_range(MV_L, MV_B)));
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 6)) queue_word(CMD_FETCH, 2'($urandom_range(0, 3)));
            end else if (pick < 88) begin
                queue_word(CMD_REWIND, 2'($urandom_range(0, 3)));
            end else if (pick < 94) begin
                queue_word(CMD_SPARE, 2'($urandom_range(0, 3)));
            end else begin
                queue_word(CMD_RECORD, MV_B);
                queue_word(CMD_RECORD, 2'($urandom_range(MV_L, MV_B)));
            end
        end
    endtask

    task automatic wait_quiet();
        while (word_queue.size() != 0 || i_valid || path_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bank(input logic sel);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= sel;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        bank_sel = sel;
    endtask

    // Sender: a new word goes out at the falling edge once the previous one was taken.
    always @(negedge i_clk) begin : drive_words
        t_move_word nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (word_queue.size() != 0) begin
                if (!gap_taken && $urandom_range(1, 100) <= send_idle_pct) begin
                    send_gap <= $urandom_range(0, 10);
                    gap_taken <= 1'b1;
                    i_valid <= 1'b0;
                end else begin
                    nxt = word_queue.pop_front();
                    i_valid <= 1'b1;
                    i_command <= nxt.cmd;
                    i_move_code <= nxt.mv;
                    gap_taken <= 1'b0;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            i_stall <= 1'b1;
        end else if (!i_stall && $urandom_range(1, 100) <= recv_idle_pct) begin
            recv_gap <= $urandom_range(0, 10);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            apply_word(i_command, i_move_code);
    end

    // Fields are shown as move/has/length/dropped.
    always @(posedge i_clk) begin : check_results
        t_path_result want;
        t_path_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_move_out, o_has_move, o_path_length, o_dropped};
            if (path_results_due.size() == 0) begin
                $display("%0t: result word with none expected: got %0d/%0d/%0d/%0d",
                         $time, got.move_out, got.has_move, got.path_len, got.dropped);
                mismatches++;
            end else begin
                want = path_results_due.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             $time, want.move_out, want.has_move, want.path_len,
                             want.dropped, got.move_out, got.has_move, got.path_len,
                             got.dropped);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("** maze_path_shortener: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_bank(1'b0);

        // Each reduction rule once, triples that stay, a fetch past the end,
        // the spare command and a rewind.
        queue_word(CMD_FETCH, MV_B);
        queue_word(CMD_RECORD, MV_L);
        queue_word(CMD_RECORD, MV_B);
        queue_word(CMD_RECORD, MV_L);
        queue_word(CMD_RECORD, MV_B);
        queue_word(CMD_RECORD, MV_L);
        queue_word(CMD_RECORD, MV_B);
        queue_word(CMD_RECORD, MV_L);
        queue_word(CMD_RECORD, MV_S);
        queue_word(CMD_RECORD, MV_B);
        queue_word(CMD_RECORD, MV_S);
        queue_word(CMD_RECORD, MV_L);
        queue_word(CMD_RECORD, MV_B);
        queue_word(CMD_RECORD, MV_S);
        queue_word(CMD_RECORD, MV_L);
        queue_word(CMD_RECORD, MV_B);
        queue_word(CMD_RECORD, MV_R);
        queue_word(CMD_RECORD, MV_B);
        queue_word(CMD_FETCH, MV_R);
        queue_word(CMD_FETCH, MV_S);
        queue_word(CMD_SPARE, MV_B);
        queue_word(CMD_REWIND, MV_R);
        queue_word(CMD_FETCH, MV_L);
        wait_quiet();

        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 4 == 0) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(5, 40);
                recv_idle_pct = $urandom_range(5, 40);
            end
            write_bank((ph < 2) ? ph[0] : 1'($urandom_range(0, 1)));
            queue_random_words(120);
            wait_quiet();
        end

        // Top up the second stack until it is full, then push into the full stack.
        write_bank(1'b1);
        while (path_cnt[1] < PATH_DEPTH) begin
            repeat (PATH_DEPTH - path_cnt[1])
                queue_word(CMD_RECORD, 2'($urandom_range(MV_L, MV_R)));
            wait_quiet();
        end
        repeat (3) queue_word(CMD_RECORD, 2'($urandom_range(MV_L, MV_B)));
        queue_word(CMD_FETCH, MV_L);
        wait_quiet();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_bank(1'b0);
        queue_random_words(100);
        wait_quiet();

        if (mismatches == 0 && path_results_due.size() == 0)
            $display("** maze_path_shortener: PASSED **");
        else
            $display("** maze_path_shortener: FAILED **");
        $finish;
    end

endmodule
